// File: hw/rtl/eta_phi_nearest_match_top_defines.svh
// Assertion macros shared by the eta/phi nearest match RTL.
`ifndef ETA_PHI_NEAREST_MATCH_TOP_DEFINES_SVH
`define ETA_PHI_NEAREST_MATCH_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, clocked by clock and disabled during reset.
`define EPM_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, clocked by clock and disabled during reset.
`define EPM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define EPM_ASSERT_IMPL(lbl, ante, cons, msg)
`define EPM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/epm_pkg.sv
// Shared types and constants of the eta/phi nearest match block.
package epm_pkg;

   localparam int ID_W       = 24;
   localparam int MOTHER_W   = 24;
   localparam int ETA_W      = 17;
   localparam int PHI_W      = 15;
   localparam int DIST_W     = 32;
   localparam int EXCL_W     = 23;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam int DETA_W = ETA_W + 1;
   localparam int DPHI_W = PHI_W + 1;
   localparam int SQE_W  = 2 * DETA_W - 1;
   localparam int SQP_W  = 28;

   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_ALL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_SQ   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXCL_MOTHER = 2'd2;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [DIST_W-1:0] DIST_MAX = 32'hFFFF_FFFF;

   localparam logic              MATCH_ALL_RESET = 1'b1;
   localparam logic [DIST_W-1:0] RADIUS_RESET    = 32'd167772;
   localparam logic [EXCL_W-1:0] EXCL_RESET      = 23'd15;

   localparam logic signed [DPHI_W-1:0] PI_FX     = 16'sd12868;
   localparam logic signed [DPHI_W-1:0] NEG_PI_FX = -16'sd12868;
   localparam logic signed [DPHI_W-1:0] TWO_PI_FX = 16'sd25736;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [MOTHER_W-1:0] abs_mother;
      logic [ETA_W-1:0]    eta;
      logic [PHI_W-1:0]    phi;
   } ref_entry_type;

   typedef struct packed {
      logic          is_query;
      logic          new_event;
      ref_entry_type entry;
   } cmd_type;

   typedef struct packed {
      logic              match_all;
      logic [DIST_W-1:0] radius_sq;
      logic [EXCL_W-1:0] excluded_mother;
   } cfg_type;

endpackage

// File: hw/rtl/epm_if.sv
// Channel interfaces: request items, response items and register writes.
interface epm_req_if;
   logic                                valid;
   logic                                ready;
   logic                                mode;
   logic                                new_event;
   logic signed [epm_pkg::ID_W-1:0]     particle_id;
   logic signed [epm_pkg::MOTHER_W-1:0] mother_id;
   logic signed [epm_pkg::ETA_W-1:0]    eta;
   logic signed [epm_pkg::PHI_W-1:0]    phi;

   modport source(output valid, mode, new_event, particle_id, mother_id, eta, phi,
                  input ready);
   modport sink(input valid, mode, new_event, particle_id, mother_id, eta, phi,
                output ready);
endinterface

interface epm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        matched;
   logic [epm_pkg::DIST_W-1:0]  best_dist_sq;

   modport source(output valid, matched, best_dist_sq, input ready);
   modport sink(input valid, matched, best_dist_sq, output ready);
endinterface

interface epm_csr_if;
   logic                            valid;
   logic                            ready;
   logic [epm_pkg::CSR_IDX_W-1:0]   index;
   logic [epm_pkg::CSR_DATA_W-1:0]  data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// File: hw/rtl/epm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module epm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/epm_front.sv
// Front end: accepts request transactions and turns them into queue commands.
module epm_front (
   epm_req_if.sink          req,
   input  logic             q_full,
   output logic             push,
   output epm_pkg::cmd_type push_cmd
);

   logic [epm_pkg::MOTHER_W-1:0] mother_neg;

   assign req.ready = !q_full;
   assign push      = req.valid && !q_full;

   // The magnitude of the most negative code is 2^23, which still fits unsigned.
   assign mother_neg = -req.mother_id;

   always_comb begin
      push_cmd.is_query  = (req.mode == epm_pkg::MODE_QUERY);
      push_cmd.new_event = req.new_event;
      push_cmd.entry.id  = req.particle_id;
      push_cmd.entry.abs_mother = req.mother_id[epm_pkg::MOTHER_W-1] ? mother_neg
                                                                     : req.mother_id;
      push_cmd.entry.eta = req.eta;
      push_cmd.entry.phi = req.phi;
   end

endmodule

// File: hw/rtl/epm_queue.sv
// Short command queue between the front end and the search engine.
`include "eta_phi_nearest_match_top_defines.svh"
module epm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  epm_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output epm_pkg::cmd_type pop_cmd,
   output logic             empty
);

   epm_pkg::cmd_type                 slot_ff [epm_pkg::QUEUE_DEPTH];
   logic [epm_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [epm_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [epm_pkg::QFILL_W-1:0]      fill_ff, fill_in;
   logic                             do_push, do_pop;

   assign full    = (fill_ff == epm_pkg::QFILL_W'(epm_pkg::QUEUE_DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `EPM_ASSERT_IMPL(a_fill_bound, 1'b1, fill_ff <= epm_pkg::QFILL_W'(epm_pkg::QUEUE_DEPTH), "queue fill exceeds depth")
   `EPM_ASSERT_NEXT(a_fill_track, do_push && !do_pop, fill_ff == $past(fill_ff) + 1'b1, "queue fill lost a push")

endmodule

// File: hw/rtl/epm_back.sv
// Back end: stores reference entries and runs the delta-R search for queries.
`include "eta_phi_nearest_match_top_defines.svh"
module epm_back #(
   parameter int MAX_REFS = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  epm_pkg::cfg_type cfg,
   input  logic             q_empty,
   input  epm_pkg::cmd_type pop_cmd,
   output logic             pop,
   epm_rsp_if.source        rsp
);

   localparam int IDX_W   = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
   localparam int CNT_W   = $clog2(MAX_REFS + 1);
   localparam int ENTRY_W = $bits(epm_pkg::ref_entry_type);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0] load_base;
   logic             load_fits;

   logic [epm_pkg::DIST_W-1:0] best_ff, best_in;
   logic                       force_ff, force_in;
   logic [epm_pkg::ID_W-1:0]   q_id_ff, q_id_in;
   logic [epm_pkg::ETA_W-1:0]  q_eta_ff, q_eta_in;
   logic [epm_pkg::PHI_W-1:0]  q_phi_ff, q_phi_in;

   logic                 ram_we;
   logic [ENTRY_W-1:0]   ram_rdata;
   epm_pkg::ref_entry_type rd_entry;

   // Search pipeline: RAM read, difference stage, square stage, minimum update.
   logic issue_vld_ff;
   logic s2_vld_ff, s2_cand_ff;
   logic s3_vld_ff, s3_cand_ff;
   logic signed [epm_pkg::DETA_W-1:0] de_in, s2_de_ff;
   logic signed [epm_pkg::DPHI_W-1:0] dp_raw, dp_in, s2_dp_ff;
   logic                              cand_in;
   logic signed [2*epm_pkg::DETA_W-1:0] prod_e;
   logic signed [2*epm_pkg::DPHI_W-1:0] prod_p;
   logic [epm_pkg::SQE_W-1:0]           s3_sqe_ff;
   logic [epm_pkg::SQP_W-1:0]           s3_sqp_ff;
   logic [epm_pkg::SQE_W:0]             dist_sum;
   logic [epm_pkg::DIST_W-1:0]          dist_sat;

   logic                       out_free, out_load;
   logic                       rsp_vld_ff;
   logic                       rsp_matched_ff;
   logic [epm_pkg::DIST_W-1:0] rsp_dist_ff;

   assign pop       = (state_ff == ST_IDLE) && !q_empty;
   assign load_base = pop_cmd.new_event ? '0 : count_ff;
   assign load_fits = (load_base < CNT_W'(MAX_REFS));
   assign ram_we    = pop && !pop_cmd.is_query && load_fits;
   assign out_free  = !rsp_vld_ff || rsp.ready;
   assign out_load  = (state_ff == ST_DONE) && out_free;

   epm_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_REFS)
   ) u_ref_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(load_base[IDX_W-1:0]),
      .wdata(pop_cmd.entry),
      .raddr(scan_idx_ff[IDX_W-1:0]),
      .rdata(ram_rdata)
   );

   assign rd_entry = epm_pkg::ref_entry_type'(ram_rdata);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      scan_idx_in = scan_idx_ff;
      force_in    = force_ff;
      q_id_in     = q_id_ff;
      q_eta_in    = q_eta_ff;
      q_phi_in    = q_phi_ff;
      best_in     = best_ff;
      if (s3_vld_ff && s3_cand_ff && (dist_sat < best_ff)) begin
         best_in = dist_sat;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               if (pop_cmd.is_query) begin
                  best_in     = epm_pkg::DIST_MAX;
                  force_in    = cfg.match_all;
                  q_id_in     = pop_cmd.entry.id;
                  q_eta_in    = pop_cmd.entry.eta;
                  q_phi_in    = pop_cmd.entry.phi;
                  scan_idx_in = '0;
                  // Match-all and an empty table both skip the search.
                  if (cfg.match_all || (count_ff == '0)) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  count_in = load_fits ? load_base + 1'b1 : load_base;
               end
            end
         end
         ST_SCAN: begin
            scan_idx_in = scan_idx_ff + 1'b1;
            if (scan_idx_ff == count_ff - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!issue_vld_ff && !s2_vld_ff && !s3_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      de_in  = $signed({rd_entry.eta[epm_pkg::ETA_W-1], rd_entry.eta})
             - $signed({q_eta_ff[epm_pkg::ETA_W-1], q_eta_ff});
      dp_raw = $signed({rd_entry.phi[epm_pkg::PHI_W-1], rd_entry.phi})
             - $signed({q_phi_ff[epm_pkg::PHI_W-1], q_phi_ff});
      // A single 2pi step brings any difference of two 15-bit angles into range.
      if (dp_raw >= epm_pkg::PI_FX) begin
         dp_in = dp_raw - epm_pkg::TWO_PI_FX;
      end else if (dp_raw < epm_pkg::NEG_PI_FX) begin
         dp_in = dp_raw + epm_pkg::TWO_PI_FX;
      end else begin
         dp_in = dp_raw;
      end
      cand_in = (rd_entry.id == q_id_ff)
             && (rd_entry.abs_mother != {1'b0, cfg.excluded_mother});
   end

   assign prod_e   = s2_de_ff * s2_de_ff;
   assign prod_p   = s2_dp_ff * s2_dp_ff;
   assign dist_sum = {1'b0, s3_sqe_ff} + (epm_pkg::SQE_W + 1)'(s3_sqp_ff);
   assign dist_sat = (dist_sum[epm_pkg::SQE_W:epm_pkg::DIST_W] != '0) ? epm_pkg::DIST_MAX
                                                                      : dist_sum[epm_pkg::DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_vld_ff <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_vld_ff <= (state_ff == ST_SCAN);
         s2_vld_ff    <= issue_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         if (out_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      best_ff     <= best_in;
      force_ff    <= force_in;
      q_id_ff     <= q_id_in;
      q_eta_ff    <= q_eta_in;
      q_phi_ff    <= q_phi_in;
      s2_de_ff    <= de_in;
      s2_dp_ff    <= dp_in;
      s2_cand_ff  <= cand_in;
      s3_sqe_ff   <= prod_e[epm_pkg::SQE_W-1:0];
      s3_sqp_ff   <= prod_p[epm_pkg::SQP_W-1:0];
      s3_cand_ff  <= s2_cand_ff;
      if (out_load) begin
         rsp_matched_ff <= force_ff || (best_ff < cfg.radius_sq);
         rsp_dist_ff    <= best_ff;
      end
   end

   assign rsp.valid        = rsp_vld_ff;
   assign rsp.matched      = rsp_matched_ff;
   assign rsp.best_dist_sq = rsp_dist_ff;

   `EPM_ASSERT_IMPL(a_scan_in_table, state_ff == ST_SCAN, scan_idx_ff < count_ff, "scan index past stored entries")
   `EPM_ASSERT_IMPL(a_done_drained, state_ff == ST_DONE, !issue_vld_ff && !s2_vld_ff && !s3_vld_ff, "result taken before pipeline drained")
   `EPM_ASSERT_NEXT(a_best_falls, state_ff == ST_SCAN || state_ff == ST_DRAIN, best_ff <= $past(best_ff), "best distance increased during search")
   `EPM_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= CNT_W'(MAX_REFS), "reference count exceeds table depth")

endmodule

// File: hw/rtl/eta_phi_nearest_match_top.sv
// Top level: register file and wiring of front end, command queue and search engine.
// A load passes through the command queue and is written to the table when the engine
// pops it; loads sustain one per cycle while the engine is idle. A query scans every
// stored entry through the single RAM read port, and the engine pops nothing more until
// its response is registered. Match-all and empty-table queries skip the scan.
// Synchronous reset empties the table count and queue and restores register defaults.
module eta_phi_nearest_match_top #(
   parameter int MAX_REFS = 256
) (
   input logic       clock,
   input logic       reset,
   epm_req_if.sink   req_chan,
   epm_rsp_if.source rsp_chan,
   epm_csr_if.sink   csr_chan
);

   epm_pkg::cfg_type cfg_ff, cfg_in;
   epm_pkg::cmd_type push_cmd, pop_cmd;
   logic             push, pop, q_full, q_empty;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            epm_pkg::CSR_MATCH_ALL:   cfg_in.match_all = csr_chan.data[0];
            epm_pkg::CSR_RADIUS_SQ:   cfg_in.radius_sq = csr_chan.data;
            epm_pkg::CSR_EXCL_MOTHER: cfg_in.excluded_mother = csr_chan.data[epm_pkg::EXCL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_all       <= epm_pkg::MATCH_ALL_RESET;
         cfg_ff.radius_sq       <= epm_pkg::RADIUS_RESET;
         cfg_ff.excluded_mother <= epm_pkg::EXCL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   epm_front u_front (
      .req     (req_chan),
      .q_full  (q_full),
      .push    (push),
      .push_cmd(push_cmd)
   );

   epm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .full    (q_full),
      .pop     (pop),
      .pop_cmd (pop_cmd),
      .empty   (q_empty)
   );

   epm_back #(
      .MAX_REFS(MAX_REFS)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .q_empty(q_empty),
      .pop_cmd(pop_cmd),
      .pop    (pop),
      .rsp    (rsp_chan)
   );

endmodule

// File: bench/tb_eta_phi_nearest_match_top.sv
// Self-checking testbench of the eta/phi nearest match block, with its own predictor.
module tb_eta_phi_nearest_match_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     MAX_REFS        = 256;
   localparam int     RANDOM_ITEMS    = 130;
   localparam int     WATCHDOG_LIMIT  = 4000;
   localparam int     QUIET_MARGIN    = 12;
   localparam int     DRAIN_CYCLES    = 300;
   localparam int     HOLD_OFF_CYCLES = 400;
   localparam int     MAX_PRINTED     = 200;
   localparam longint DIST_SAT        = longint'(epm_pkg::DIST_MAX);
   localparam int     MOST_NEG_ID     = -8388608;
   localparam int     MAX_POS_ID      = 8388607;

   typedef struct packed {
      logic                                mode;
      logic                                new_event;
      logic signed [epm_pkg::ID_W-1:0]     particle_id;
      logic signed [epm_pkg::MOTHER_W-1:0] mother_id;
      logic signed [epm_pkg::ETA_W-1:0]    eta;
      logic signed [epm_pkg::PHI_W-1:0]    phi;
   } particle_item_type;

   typedef struct packed {
      logic signed [epm_pkg::ID_W-1:0]     id;
      logic signed [epm_pkg::MOTHER_W-1:0] mother;
      logic signed [epm_pkg::ETA_W-1:0]    eta;
      logic signed [epm_pkg::PHI_W-1:0]    phi;
   } stored_particle_type;

   typedef struct packed {
      logic                       matched;
      logic [epm_pkg::DIST_W-1:0] best_dist_sq;
   } match_result_type;

   logic clock;
   logic reset;

   epm_req_if req_bus();
   epm_rsp_if rsp_bus();
   epm_csr_if csr_bus();

   eta_phi_nearest_match_top #(
      .MAX_REFS(MAX_REFS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_chan(csr_bus)
   );

   // Predictor state: stored reference particles and register copies.
   stored_particle_type        particle_store [MAX_REFS];
   int unsigned                stored_count;
   logic                       cfg_match_all;
   logic [epm_pkg::DIST_W-1:0] cfg_radius_sq;
   logic [epm_pkg::EXCL_W-1:0] cfg_excluded;

   match_result_type pending_results [$];
   int               error_count;
   int               stalled_cycles;
   int               rsp_hold_request;
   bit               req_idle_en;
   bit               rsp_stall_en;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic flag_error(input string msg);
      if (error_count < MAX_PRINTED) $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 93) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic int sender_gap();
      if (!req_idle_en || $urandom_range(0, 99) < 50) return 0;
      return idle_length();
   endfunction

   function automatic longint squared_delta_r(input stored_particle_type e,
                                              input logic signed [epm_pkg::ETA_W-1:0] eta,
                                              input logic signed [epm_pkg::PHI_W-1:0] phi);
      longint de, dp, d;
      de = longint'(e.eta) - longint'(eta);
      dp = longint'(e.phi) - longint'(phi);
      // Azimuth difference is folded into [-pi, pi) one full turn at a time.
      while (dp >= longint'(epm_pkg::PI_FX)) dp -= longint'(epm_pkg::TWO_PI_FX);
      while (dp < longint'(epm_pkg::NEG_PI_FX)) dp += longint'(epm_pkg::TWO_PI_FX);
      d = de * de + dp * dp;
      return (d > DIST_SAT) ? DIST_SAT : d;
   endfunction

   function automatic match_result_type predict_nearest(input particle_item_type item);
      match_result_type res;
      longint best, d, mo;
      best = DIST_SAT;
      if (cfg_match_all) begin
         res.matched = 1'b1;
         res.best_dist_sq = epm_pkg::DIST_MAX;
         return res;
      end
      for (int i = 0; i < stored_count; i++) begin
         mo = longint'(particle_store[i].mother);
         if (mo < 0) mo = -mo;
         if (particle_store[i].id == item.particle_id && mo != longint'(cfg_excluded)) begin
            d = squared_delta_r(particle_store[i], item.eta, item.phi);
            if (d < best) best = d;
         end
      end
      res.matched = (best < longint'(cfg_radius_sq));
      res.best_dist_sq = best[epm_pkg::DIST_W-1:0];
      return res;
   endfunction

   task automatic record_accepted_item(input particle_item_type item);
      if (item.mode == epm_pkg::MODE_LOAD) begin
         if (item.new_event) stored_count = 0;
         // A load into a full table is dropped.
         if (stored_count < MAX_REFS) begin
            particle_store[stored_count] = '{item.particle_id, item.mother_id,
                                             item.eta, item.phi};
            stored_count++;
         end
      end else begin
         pending_results.push_back(predict_nearest(item));
      end
   endtask

   function automatic particle_item_type make_item(input logic mode, input logic ne,
                                                   input int id, input int mo,
                                                   input int eta, input int phi);
      particle_item_type item;
      item.mode = mode;
      item.new_event = ne;
      item.particle_id = epm_pkg::ID_W'(id);
      item.mother_id = epm_pkg::MOTHER_W'(mo);
      item.eta = epm_pkg::ETA_W'(eta);
      item.phi = epm_pkg::PHI_W'(phi);
      return item;
   endfunction

   // Holds valid until the transaction completes; valid stays high when no gap follows.
   task automatic send_item(input particle_item_type item);
      int gap;
      req_bus.valid       <= 1'b1;
      req_bus.mode        <= item.mode;
      req_bus.new_event   <= item.new_event;
      req_bus.particle_id <= item.particle_id;
      req_bus.mother_id   <= item.mother_id;
      req_bus.eta         <= item.eta;
      req_bus.phi         <= item.phi;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      record_accepted_item(item);
      gap = sender_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_load(input logic ne, input int id, input int mo,
                            input int eta, input int phi);
      send_item(make_item(epm_pkg::MODE_LOAD, ne, id, mo, eta, phi));
   endtask

   task automatic send_query(input int id, input int eta, input int phi);
      send_item(make_item(epm_pkg::MODE_QUERY, 1'b0, id, int'($urandom), eta, phi));
   endtask

   // Always lets at least one edge pass, so valid is never lowered and raised in one step.
   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_register(input logic [epm_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [epm_pkg::CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         epm_pkg::CSR_MATCH_ALL:   cfg_match_all = data[0];
         epm_pkg::CSR_RADIUS_SQ:   cfg_radius_sq = data;
         epm_pkg::CSR_EXCL_MOTHER: cfg_excluded  = data[epm_pkg::EXCL_W-1:0];
         default: ;
      endcase
   endtask

   // Registers change only once the block is idle, including the tail of a pending load.
   task automatic configure(input logic ma, input logic [epm_pkg::DIST_W-1:0] radius,
                            input logic [epm_pkg::EXCL_W-1:0] excl);
      wait_until_drained();
      repeat (stored_count + QUIET_MARGIN) @(posedge clock);
      write_register(epm_pkg::CSR_MATCH_ALL, {{(epm_pkg::CSR_DATA_W-1){1'b0}}, ma});
      write_register(epm_pkg::CSR_RADIUS_SQ, radius);
      write_register(epm_pkg::CSR_EXCL_MOTHER,
                     {{(epm_pkg::CSR_DATA_W-epm_pkg::EXCL_W){1'b0}}, excl});
      csr_bus.valid <= 1'b0;
   endtask

   task automatic test_match_all_default();
      send_load(1'b1, 1, 2, 0, 0);
      send_load(1'b0, 1, 3, 40, -40);
      send_query(1, 0, 0);
      send_query(9, 100, 100);
      send_item(make_item(epm_pkg::MODE_QUERY, 1'b1, 1, 0, 0, 0));
   endtask

   task automatic test_directed_cases();
      configure(1'b0, epm_pkg::RADIUS_RESET, epm_pkg::EXCL_RESET);
      send_load(1'b1, 11, 23, 0, 0);
      send_load(1'b0, 11, -15, 10, 10);
      send_load(1'b0, 11, 15, 5, 5);
      send_load(1'b0, 11, MOST_NEG_ID, 400, 12868);
      send_load(1'b0, MOST_NEG_ID, MAX_POS_ID, -65536, -16384);
      send_load(1'b0, MAX_POS_ID, 1, 65535, 16383);
      send_load(1'b0, 22, 1, 100, 0);
      send_load(1'b0, 22, 2, -100, 0);
      send_query(11, 30, 40);
      // Opposite sides of the wrap point are a zero azimuth difference apart.
      send_query(11, 400, -12868);
      send_query(MOST_NEG_ID, 65535, 16383);
      send_query(MAX_POS_ID, -1, -16384);
      send_query(MAX_POS_ID, 1, 16383);
      send_query(22, 0, 0);
      send_query(99, 0, 0);
      send_item(make_item(epm_pkg::MODE_QUERY, 1'b1, 11, -1, 0, 0));
      send_load(1'b1, 5, 0, 0, 0);
      send_query(11, 0, 0);
      send_query(5, 1, 1);
   endtask

   task automatic test_register_extremes();
      configure(1'b0, '0, '0);
      send_query(5, 0, 0);
      send_load(1'b0, 5, MAX_POS_ID, 3, -4);
      send_query(5, 0, 0);
      configure(1'b0, epm_pkg::DIST_MAX, {epm_pkg::EXCL_W{1'b1}});
      send_query(5, 0, 0);
      send_query(77, 0, 0);
      configure(1'b1, '0, '0);
      send_query(5, 0, 0);
      send_query(77, 12, 12);
   endtask

   task automatic test_table_full();
      configure(1'b0, epm_pkg::RADIUS_RESET, epm_pkg::EXCL_RESET);
      for (int i = 0; i < MAX_REFS; i++) send_load(i == 0, i % 4, i + 100, i * 8, i * 3 - 300);
      send_load(1'b0, 3, 1, 5000, 0);
      send_load(1'b0, 0, 1, 7000, 7000);
      send_query(3, 5000, 0);
      send_query(0, 0, -300);
      send_query(0, 7000, 7000);
      send_load(1'b1, 3, 1, 5000, 0);
      send_query(3, 5000, 0);
   endtask

   task automatic test_backpressure();
      configure(1'b0, epm_pkg::RADIUS_RESET, epm_pkg::EXCL_RESET);
      send_load(1'b1, 4, 7, 0, 0);
      for (int i = 1; i < 8; i++) send_load(1'b0, 4, 7 + i, i * 50, -i * 50);
      req_idle_en = 1'b0;
      rsp_hold_request = HOLD_OFF_CYCLES;
      for (int i = 0; i < 12; i++) send_query(4, i * 20, -i * 20);
      wait_until_drained();
      req_idle_en = 1'b1;
      for (int i = 0; i < 4; i++) send_query(4, i * 45, i * 45);
   endtask

   function automatic particle_item_type noise_item();
      particle_item_type item;
      item.mode = 1'($urandom);
      item.new_event = 1'($urandom);
      item.particle_id = epm_pkg::ID_W'($urandom);
      item.mother_id = epm_pkg::MOTHER_W'($urandom);
      item.eta = epm_pkg::ETA_W'($urandom);
      item.phi = epm_pkg::PHI_W'($urandom);
      return item;
   endfunction

   task automatic test_random_traffic();
      logic signed [epm_pkg::ID_W-1:0] id_pool [3];
      logic [epm_pkg::DIST_W-1:0]      radius;
      logic [epm_pkg::EXCL_W-1:0]      excl;
      particle_item_type               item;
      stored_particle_type             near;
      int                              sent, n_loads, n_queries;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0: radius = '0;
            1: radius = epm_pkg::RADIUS_RESET;
            2: radius = $urandom_range(0, 1 << 22);
            3: radius = $urandom_range(0, 1 << 26);
            4: radius = $urandom;
            default: radius = epm_pkg::DIST_MAX;
         endcase
         case ($urandom_range(0, 4))
            0: excl = '0;
            1: excl = epm_pkg::EXCL_RESET;
            2: excl = epm_pkg::EXCL_W'($urandom);
            3: excl = {epm_pkg::EXCL_W{1'b1}};
            default: excl = epm_pkg::EXCL_W'($urandom_range(1, 40));
         endcase
         configure($urandom_range(0, 99) < 15, radius, excl);
         req_idle_en  = $urandom_range(0, 3) != 0;
         rsp_stall_en = $urandom_range(0, 3) != 0;
         id_pool[0] = epm_pkg::ID_W'($urandom_range(0, 30));
         id_pool[1] = epm_pkg::ID_W'(-int'($urandom_range(1, 30)));
         id_pool[2] = epm_pkg::ID_W'($urandom);
         for (int ev = 0; ev < 4 && sent < RANDOM_ITEMS; ev++) begin
            n_loads   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 10);
            n_queries = $urandom_range(1, 6);
            for (int k = 0; k <= n_loads + n_queries; k++) begin
               if ($urandom_range(0, 99) < 12) begin
                  send_item(noise_item());
                  sent++;
               end
               item = noise_item();
               if (k <= n_loads) begin
                  item.mode = epm_pkg::MODE_LOAD;
                  item.new_event = (k == 0);
                  item.particle_id = id_pool[$urandom_range(0, 2)];
                  case ($urandom_range(0, 5))
                     0: item.mother_id = epm_pkg::MOTHER_W'(cfg_excluded);
                     1: item.mother_id = -(epm_pkg::MOTHER_W'(cfg_excluded));
                     2: item.mother_id = epm_pkg::MOTHER_W'(MOST_NEG_ID);
                     default: ;
                  endcase
                  if ($urandom_range(0, 9) != 0) begin
                     item.eta = epm_pkg::ETA_W'(int'($urandom_range(0, 4000)) - 2000);
                     item.phi = epm_pkg::PHI_W'(int'($urandom_range(0, 25736)) - 12868);
                  end
               end else begin
                  item.mode = epm_pkg::MODE_QUERY;
                  if ($urandom_range(0, 99) < 85) item.particle_id = id_pool[$urandom_range(0, 2)];
                  // Most queries land close to a stored particle so that matches occur.
                  if (stored_count > 0 && $urandom_range(0, 9) != 0) begin
                     near = particle_store[$urandom_range(0, stored_count - 1)];
                     item.eta = epm_pkg::ETA_W'(int'(near.eta)
                                                + int'($urandom_range(0, 1000)) - 500);
                     item.phi = epm_pkg::PHI_W'(int'(near.phi)
                                                + int'($urandom_range(0, 1000)) - 500);
                  end
               end
               send_item(item);
               sent++;
            end
            if ($urandom_range(0, 9) == 0) wait_until_drained();
         end
      end
   endtask

   initial begin : response_sink
      int               hold_left, stall_left, rsp_index;
      match_result_type want;
      hold_left = 0;
      stall_left = 0;
      rsp_index = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               flag_error($sformatf("response %0d arrived with no query outstanding",
                                    rsp_index));
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.matched !== want.matched)
                  flag_error($sformatf("response %0d: matched %b, expected %b",
                                       rsp_index, rsp_bus.matched, want.matched));
               if (rsp_bus.best_dist_sq !== want.best_dist_sq)
                  flag_error($sformatf("response %0d: best_dist_sq %0d, expected %0d",
                                       rsp_index, rsp_bus.best_dist_sq, want.best_dist_sq));
            end
            rsp_index++;
         end
         if (rsp_hold_request > 0) begin
            hold_left = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (rsp_stall_en && $urandom_range(0, 99) < 20) begin
            stall_left = idle_length() - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Ends the run when no transaction of any kind completes for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin : test_sequence
      reset = 1'b1;
      error_count = 0;
      stalled_cycles = 0;
      rsp_hold_request = 0;
      req_idle_en = 1'b1;
      rsp_stall_en = 1'b1;
      stored_count = 0;
      cfg_match_all = epm_pkg::MATCH_ALL_RESET;
      cfg_radius_sq = epm_pkg::RADIUS_RESET;
      cfg_excluded = epm_pkg::EXCL_RESET;
      req_bus.valid       <= 1'b0;
      req_bus.mode        <= epm_pkg::MODE_LOAD;
      req_bus.new_event   <= 1'b0;
      req_bus.particle_id <= '0;
      req_bus.mother_id   <= '0;
      req_bus.eta         <= '0;
      req_bus.phi         <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.index       <= epm_pkg::CSR_MATCH_ALL;
      csr_bus.data        <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_match_all_default();
      test_directed_cases();
      test_register_extremes();
      test_table_full();
      test_backpressure();
      test_random_traffic();
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         flag_error($sformatf("%0d responses never arrived", pending_results.size()));
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
